### hdl/bcmr_pkg.sv
// Shared types, constants and helpers for the box collision move resolver.
package bcmr_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int COORD_BITS  = 16;
    localparam int DIM_W       = 15;
    localparam int IDX_FIELD_W = 6;
    localparam int FUNC_W      = 2;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int SKIP_W      = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;
    localparam int SUM_W       = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 3;
    localparam int OFF_W       = COORD_BITS + 1;

    typedef logic signed [COORD_BITS-1:0]  t_coord;
    typedef logic        [DIM_W-1:0]       t_dim;
    typedef logic signed [SUM_W-1:0]       t_sum;
    typedef logic signed [OFF_W-1:0]       t_off;
    typedef logic        [IDX_W-1:0]       t_idx;
    typedef logic        [IDX_FIELD_W-1:0] t_idx_field;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_MOVE  = 2'd1,
        FUNC_FIND  = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        t_idx_field        index;
        logic              entry_present;
        t_coord            box_left;
        t_coord            box_top;
        t_dim              box_width;
        t_dim              box_height;
        t_coord            cur_x;
        t_coord            cur_y;
        t_coord            next_x;
        t_coord            next_y;
    } t_cmd;

    typedef struct packed {
        t_coord     final_x;
        t_coord     final_y;
        logic       hit_found;
        t_idx_field hit_index;
    } t_result;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_dim   width;
        t_dim   height;
    } t_entry;

    typedef struct packed {
        logic load;
        logic wr;
        logic step;
        logic advance;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic hit;
        logic more;
        logic last;
        logic find;
    } t_dp_stat;

    function automatic t_sum sx_coord(input t_coord v);
        return t_sum'(v);
    endfunction

    function automatic t_sum zx_dim(input t_dim v);
        return t_sum'({1'b0, v});
    endfunction

endpackage

### hdl/bcmr_dp.sv
// Datapath: box table, scan index, offset stepping, overlap test and result register.
module bcmr_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcmr_pkg::t_cmd     i_cmd,
    input  bcmr_pkg::t_dp_cmd  i_ctl,
    output bcmr_pkg::t_dp_stat o_stat,
    output bcmr_pkg::t_result  o_result
);
    import bcmr_pkg::*;

    t_entry     r_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] r_valid;
    t_entry     r_rd;
    t_idx       r_k, n_k;
    t_off       r_ox, r_oy, n_ox, n_oy;
    t_sum       r_ml, r_mt, n_ml, n_mt;
    t_dim       r_bw, r_bh;
    t_coord     r_cx, r_cy;
    t_idx_field r_self;
    logic       r_find;
    t_result    r_res;

    logic   in_range;
    t_idx   wr_addr;
    logic   self_match;
    logic   overlap;
    logic   hit;
    t_sum   el, et, ew, eh;

    assign in_range = int'(i_cmd.index) < MAX_ENTRIES;
    assign wr_addr  = t_idx'(i_cmd.index);

    // table write and registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && in_range) begin
            r_mem[wr_addr] <= '{left: i_cmd.box_left, top: i_cmd.box_top,
                                width: i_cmd.box_width, height: i_cmd.box_height};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[n_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ctl.wr && in_range) begin
            r_valid[wr_addr] <= i_cmd.entry_present;
        end
    end

    // overlap test against the entry at r_k, inclusive edges
    always_comb begin
        el = sx_coord(r_rd.left);
        et = sx_coord(r_rd.top);
        ew = zx_dim(r_rd.width);
        eh = zx_dim(r_rd.height);
        overlap = (el <= r_ml + zx_dim(r_bw)) && (el + ew >= r_ml) &&
                  (et <= r_mt + zx_dim(r_bh)) && (et + eh >= r_mt);
    end

    assign self_match = SKIP_W'(r_k) == SKIP_W'(r_self);
    assign hit        = r_valid[r_k] && !self_match && overlap;

    // one unit toward zero on each nonzero component
    always_comb begin
        n_ox = r_ox;
        n_oy = r_oy;
        n_ml = r_ml;
        n_mt = r_mt;
        if (i_ctl.step) begin
            if (r_ox > 0) begin
                n_ox = r_ox - t_off'(1);
                n_ml = r_ml - t_sum'(1);
            end else if (r_ox < 0) begin
                n_ox = r_ox + t_off'(1);
                n_ml = r_ml + t_sum'(1);
            end
            if (r_oy > 0) begin
                n_oy = r_oy - t_off'(1);
                n_mt = r_mt - t_sum'(1);
            end else if (r_oy < 0) begin
                n_oy = r_oy + t_off'(1);
                n_mt = r_mt + t_sum'(1);
            end
        end
    end

    always_comb begin
        priority if (i_ctl.load) begin
            n_k = '0;
        end else if (i_ctl.advance) begin
            n_k = r_k + t_idx'(1);
        end else begin
            n_k = r_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;
        if (i_ctl.load) begin
            r_find <= i_cmd.func == FUNC_FIND;
            r_self <= i_cmd.index;
            r_bw   <= i_cmd.box_width;
            r_bh   <= i_cmd.box_height;
            r_cx   <= i_cmd.cur_x;
            r_cy   <= i_cmd.cur_y;
            if (i_cmd.func == FUNC_FIND) begin
                r_ox <= '0;
                r_oy <= '0;
                r_ml <= sx_coord(i_cmd.box_left) + sx_coord(i_cmd.cur_x);
                r_mt <= sx_coord(i_cmd.box_top) + sx_coord(i_cmd.cur_y);
            end else begin
                r_ox <= t_off'(i_cmd.next_x) - t_off'(i_cmd.cur_x);
                r_oy <= t_off'(i_cmd.next_y) - t_off'(i_cmd.cur_y);
                r_ml <= sx_coord(i_cmd.box_left) + sx_coord(i_cmd.next_x);
                r_mt <= sx_coord(i_cmd.box_top) + sx_coord(i_cmd.next_y);
            end
        end else begin
            r_ox <= n_ox;
            r_oy <= n_oy;
            r_ml <= n_ml;
            r_mt <= n_mt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            if (r_find) begin
                r_res.final_x   <= '0;
                r_res.final_y   <= '0;
                r_res.hit_found <= hit;
                r_res.hit_index <= hit ? t_idx_field'(r_k) : '0;
            end else begin
                r_res.final_x   <= t_coord'(t_off'(r_cx) + n_ox);
                r_res.final_y   <= t_coord'(t_off'(r_cy) + n_oy);
                r_res.hit_found <= 1'b0;
                r_res.hit_index <= '0;
            end
        end
    end

    assign o_stat.hit  = hit;
    assign o_stat.more = (n_ox != 0) || (n_oy != 0);
    assign o_stat.last = r_k == t_idx'(MAX_ENTRIES - 1);
    assign o_stat.find = r_find;
    assign o_result    = r_res;

endmodule

### hdl/bcmr_ctrl.sv
// Controller: accepts words, sequences the table scan and raises the result strobe.
module bcmr_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bcmr_pkg::FUNC_W-1:0] i_func,
    input  bcmr_pkg::t_dp_stat          i_stat,
    output bcmr_pkg::t_dp_cmd           o_ctl,
    output logic                        o_busy,
    output logic                        o_result_valid
);
    import bcmr_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_func == FUNC_WRITE) begin
                        o_ctl.wr = 1'b1;
                    end else if (i_func == FUNC_MOVE || i_func == FUNC_FIND) begin
                        o_ctl.load = 1'b1;
                        n_state    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_stat.find) begin
                    if (i_stat.hit || i_stat.last) begin
                        o_ctl.finish = 1'b1;
                        n_state      = ST_OUT;
                    end else begin
                        o_ctl.advance = 1'b1;
                    end
                end else begin
                    o_ctl.step = i_stat.hit;
                    if (i_stat.hit && i_stat.more) begin
                        n_state = ST_SCAN;
                    end else if (i_stat.last) begin
                        o_ctl.finish = 1'b1;
                        n_state      = ST_OUT;
                    end else begin
                        o_ctl.advance = 1'b1;
                    end
                end
            end
            ST_OUT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy         = r_state != ST_IDLE;
    assign o_result_valid = r_state == ST_OUT;

endmodule

### hdl/box_collision_move_resolver_top.sv
// A table write takes effect at the accept edge and returns no word.
// A query tests one entry per cycle (all MAX_ENTRIES for a move, up to the first hit for
// a find); a move retests an entry after each hit that leaves its stepped offset nonzero.
// The result is registered as the scan finishes and is strobed while in ST_OUT.
// Busy stays high until ST_OUT is left; writes can follow every cycle; a query holds busy.
// Sync reset clears all valid marks at once; table contents undefined until written.
module box_collision_move_resolver_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bcmr_pkg::t_cmd    i_cmd,
    output logic              o_result_valid,
    output bcmr_pkg::t_result o_result
);
    import bcmr_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    bcmr_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_func         (i_cmd.func),
        .i_stat         (stat),
        .o_ctl          (ctl),
        .o_busy         (busy),
        .o_result_valid (o_result_valid)
    );

    bcmr_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_stat   (stat),
        .o_result (o_result)
    );

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a query in flight");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    a_write_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd.func == FUNC_WRITE) |=> !busy)
        else $error("table write made the block busy");

    a_miss_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.hit_found) |-> (o_result.hit_index == '0))
        else $error("hit index set without a hit");

endmodule

### verif/tb_box_collision_move_resolver_top.sv
// Self-checking testbench for the box collision move resolver: table writes, moves and hit queries.
module tb_box_collision_move_resolver_top;
    import bcmr_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_SPARE     = 2'd3;
    localparam int                WATCHDOG_LIMIT = 200000;
    localparam int                RANDOM_WORDS   = 1550;
    localparam int                MAX_REPORTS    = 10;

    typedef struct {
        t_cmd cmd;
        int   gap;
        bit   drain;
    } t_cmd_slot;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_cmd    i_cmd   = '0;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    t_cmd_slot cmd_queue[$];
    t_result   pending_results[$];

    int tbl_left [MAX_ENTRIES];
    int tbl_top  [MAX_ENTRIES];
    int tbl_w    [MAX_ENTRIES];
    int tbl_h    [MAX_ENTRIES];
    bit tbl_valid[MAX_ENTRIES];

    bit word_taken   = 1'b0;
    int idle_cycles  = 0;
    int fail_cnt     = 0;
    int n_results    = 0;
    int cnt_write    = 0;
    int cnt_move     = 0;
    int cnt_find     = 0;
    int cnt_blocked  = 0;
    int cnt_hit      = 0;
    int cnt_ignored  = 0;
    bit quiet        = 1'b0;

    box_collision_move_resolver_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit box_touches(int k, int al, int at, int aw, int ah);
        return tbl_left[k] <= al + aw && tbl_left[k] + tbl_w[k] >= al &&
               tbl_top[k] <= at + ah && tbl_top[k] + tbl_h[k] >= at;
    endfunction

    // Updates the shadow table; returns 1 when the word produces a result.
    function automatic bit resolve_cmd(input t_cmd c, output t_result r);
        int bl, bt, bw, bh, cx, cy, nx, ny, ox, oy, ml, mt, k;
        bl = c.box_left;
        bt = c.box_top;
        bw = c.box_width;
        bh = c.box_height;
        cx = c.cur_x;
        cy = c.cur_y;
        nx = c.next_x;
        ny = c.next_y;
        r  = '0;
        if (c.func == FUNC_WRITE) begin
            tbl_left[c.index]  = bl;
            tbl_top[c.index]   = bt;
            tbl_w[c.index]     = bw;
            tbl_h[c.index]     = bh;
            tbl_valid[c.index] = c.entry_present;
            cnt_write++;
            return 1'b0;
        end
        if (c.func == FUNC_MOVE) begin
            ox = nx - cx;
            oy = ny - cy;
            ml = bl + nx;
            mt = bt + ny;
            k  = 0;
            while (k < MAX_ENTRIES) begin
                if (tbl_valid[k] && k != c.index && box_touches(k, ml, mt, bw, bh)) begin
                    if (ox > 0) begin
                        ox--;
                        ml--;
                    end else if (ox < 0) begin
                        ox++;
                        ml++;
                    end
                    if (oy > 0) begin
                        oy--;
                        mt--;
                    end else if (oy < 0) begin
                        oy++;
                        mt++;
                    end
                    if (ox != 0 || oy != 0) continue;
                end
                k++;
            end
            r.final_x = t_coord'(cx + ox);
            r.final_y = t_coord'(cy + oy);
            cnt_move++;
            if (cx + ox != nx || cy + oy != ny) cnt_blocked++;
            return 1'b1;
        end
        if (c.func == FUNC_FIND) begin
            ml = bl + cx;
            mt = bt + cy;
            for (k = 0; k < MAX_ENTRIES; k++) begin
                if (tbl_valid[k] && k != c.index && box_touches(k, ml, mt, bw, bh)) begin
                    r.hit_found = 1'b1;
                    r.hit_index = t_idx_field'(k);
                    cnt_hit++;
                    break;
                end
            end
            cnt_find++;
            return 1'b1;
        end
        cnt_ignored++;
        return 1'b0;
    endfunction

    // Result check, word acceptance and watchdog.
    always @(posedge i_clk) begin
        t_result want;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_result_valid) begin
                moved = 1'b1;
                n_results++;
                if (pending_results.size() == 0) begin
                    if (fail_cnt < MAX_REPORTS)
                        $display("ERROR: result with none expected: fx=%0d fy=%0d hit=%0b idx=%0d",
                                 o_result.final_x, o_result.final_y, o_result.hit_found,
                                 o_result.hit_index);
                    fail_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.final_x !== want.final_x || o_result.final_y !== want.final_y ||
                        o_result.hit_found !== want.hit_found ||
                        o_result.hit_index !== want.hit_index) begin
                        if (fail_cnt < MAX_REPORTS)
                            $display("ERROR: exp fx=%0d fy=%0d hit=%0b idx=%0d, got fx=%0d fy=%0d hit=%0b idx=%0d",
                                     want.final_x, want.final_y, want.hit_found, want.hit_index,
                                     o_result.final_x, o_result.final_y, o_result.hit_found,
                                     o_result.hit_index);
                        fail_cnt++;
                    end
                end
            end
            if (start && !busy) begin
                moved = 1'b1;
                word_taken = 1'b1;
                if (resolve_cmd(i_cmd, want))
                    pending_results.insert(pending_results.size(), want);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: watchdog expired with %0d results outstanding",
                         pending_results.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Command driver.
    always @(negedge i_clk) begin
        logic nxt_start;
        t_cmd nxt_cmd;
        nxt_start = start;
        nxt_cmd   = i_cmd;
        if (i_rst_n) begin
            if (word_taken) begin
                word_taken = 1'b0;
                nxt_start  = 1'b0;
            end
            if (!nxt_start && cmd_queue.size() != 0) begin
                if (cmd_queue[0].gap > 0) begin
                    cmd_queue[0].gap = cmd_queue[0].gap - 1;
                end else if (!cmd_queue[0].drain ||
                             (pending_results.size() == 0 && !busy)) begin
                    nxt_cmd   = cmd_queue[0].cmd;
                    nxt_start = 1'b1;
                    cmd_queue.delete(0);
                end
            end
        end
        start <= nxt_start;
        i_cmd <= nxt_cmd;
    end

    function automatic void push_cmd(t_cmd c, bit drain);
        t_cmd_slot s;
        s.cmd   = c;
        s.gap   = quiet ? 0 : $urandom_range(0, 16);
        s.drain = drain;
        cmd_queue.insert(cmd_queue.size(), s);
    endfunction

    function automatic t_cmd mk(logic [FUNC_W-1:0] func, int idx, bit present,
                                int bl, int bt, int bw, int bh,
                                int cx, int cy, int nx, int ny);
        t_cmd c;
        c.func          = func;
        c.index         = t_idx_field'(idx);
        c.entry_present = present;
        c.box_left      = t_coord'(bl);
        c.box_top       = t_coord'(bt);
        c.box_width     = t_dim'(bw);
        c.box_height    = t_dim'(bh);
        c.cur_x         = t_coord'(cx);
        c.cur_y         = t_coord'(cy);
        c.next_x        = t_coord'(nx);
        c.next_y        = t_coord'(ny);
        return c;
    endfunction

    function automatic int near_coord();
        return $urandom_range(0, 320) - 160;
    endfunction

    function automatic int full_coord();
        return $urandom_range(0, 65535) - 32768;
    endfunction

    function automatic int pick_coord(int far_pct);
        return ($urandom_range(0, 99) < far_pct) ? full_coord() : near_coord();
    endfunction

    function automatic int pick_dim(int cap, int full_pct);
        return ($urandom_range(0, 99) < full_pct) ? $urandom_range(0, 32767)
                                                  : $urandom_range(0, cap);
    endfunction

    initial begin
        int            n_gen, r, cx, cy, nx, ny, ox, oy;
        logic [159:0]  raw;
        t_cmd          c;

        // directed: extremes, inclusive edges, self skip, zero offset, removal
        quiet = 1'b1;
        push_cmd(mk(FUNC_FIND, 0, 0, 0, 0, 4, 4, 0, 0, 0, 0), 0);
        push_cmd(mk(FUNC_WRITE, 0, 1, 0, 0, 10, 10, 0, 0, 0, 0), 0);
        push_cmd(mk(FUNC_WRITE, 63, 1, -32768, -32768, 32767, 32767, 0, 0, 0, 0), 0);
        push_cmd(mk(FUNC_WRITE, 5, 1, 32767, 32767, 0, 0, 0, 0, 0, 0), 0);
        push_cmd(mk(FUNC_WRITE, 9, 0, 100, 100, 20, 20, 0, 0, 0, 0), 0);
        push_cmd(mk(FUNC_FIND, 7, 0, 0, 0, 1, 1, 10, 10, 0, 0), 0);
        push_cmd(mk(FUNC_FIND, 0, 0, 0, 0, 1, 1, 10, 10, 0, 0), 0);
        push_cmd(mk(FUNC_FIND, 7, 0, 0, 0, 0, 0, -1, -1, 0, 0), 0);
        push_cmd(mk(FUNC_MOVE, 7, 0, 0, 0, 3, 3, -30, 2, -5, 2), 0);
        push_cmd(mk(FUNC_MOVE, 7, 0, 0, 0, 3, 3, 4, 4, 4, 4), 0);
        push_cmd(mk(FUNC_MOVE, 7, 0, 0, 0, 3, 3, 20, 20, 8, 6), 0);
        push_cmd(mk(FUNC_MOVE, 0, 0, 0, 0, 3, 3, -30, 2, -5, 2), 0);
        push_cmd(mk(FUNC_MOVE, 1, 0, 0, 0, 0, 0, 32767, 32767, -32768, -32768), 0);
        push_cmd(mk(FUNC_FIND, 2, 0, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0), 0);
        push_cmd(mk(FUNC_FIND, 2, 0, -32768, -32768, 0, 0, -32768, -32768, 0, 0), 0);
        push_cmd(mk(FUNC_FIND, 2, 0, 0, 0, 0, 0, -32768, -32768, 0, 0), 0);
        push_cmd(mk(FUNC_SPARE, 3, 1, -1, -1, 32767, 32767, -1, -1, -1, -1), 0);
        push_cmd(mk(FUNC_WRITE, 0, 0, 0, 0, 10, 10, 0, 0, 0, 0), 1);
        push_cmd(mk(FUNC_FIND, 7, 0, 0, 0, 1, 1, 5, 5, 0, 0), 0);
        push_cmd(mk(FUNC_WRITE, 12, 1, 0, 0, 0, 0, 0, 0, 0, 0), 0);
        push_cmd(mk(FUNC_MOVE, 3, 0, 0, 0, 0, 0, -10, -3, 3, 0), 0);
        push_cmd(mk(FUNC_MOVE, 3, 0, 0, 0, 2, 2, 10, 10, -2, -2), 0);
        push_cmd(mk(FUNC_WRITE, 63, 0, -32768, -32768, 32767, 32767, 0, 0, 0, 0), 0);
        push_cmd(mk(FUNC_MOVE, 4, 0, 0, 0, 0, 0, -32768, 32767, 32767, -32768), 0);
        push_cmd(mk(FUNC_FIND, 63, 0, -5, -5, 20, 20, 0, 0, 0, 0), 1);

        // random: a crowded region so moves collide, with some far and raw words
        n_gen = 0;
        while (n_gen < RANDOM_WORDS) begin
            if (n_gen % 60 == 0) quiet = ($urandom_range(0, 2) == 0);
            r = $urandom_range(0, 99);
            if (r < 30) begin
                c = mk(FUNC_WRITE, $urandom_range(0, 63), $urandom_range(0, 4) != 0,
                       pick_coord(15), pick_coord(15), pick_dim(48, 15), pick_dim(48, 15),
                       full_coord(), full_coord(), full_coord(), full_coord());
            end else if (r < 65) begin
                cx = pick_coord(10);
                cy = pick_coord(10);
                if ($urandom_range(0, 99) == 0) begin
                    nx = full_coord();
                    ny = full_coord();
                end else begin
                    ox = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 24) - 12;
                    oy = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 24) - 12;
                    nx = (cx + ox > 32767 || cx + ox < -32768) ? cx - ox : cx + ox;
                    ny = (cy + oy > 32767 || cy + oy < -32768) ? cy - oy : cy + oy;
                end
                c = mk(FUNC_MOVE, $urandom_range(0, 63), $urandom_range(0, 1),
                       ($urandom_range(0, 9) == 0) ? full_coord() : $urandom_range(0, 16) - 8,
                       ($urandom_range(0, 9) == 0) ? full_coord() : $urandom_range(0, 16) - 8,
                       pick_dim(24, 5), pick_dim(24, 5), cx, cy, nx, ny);
            end else if (r < 95) begin
                c = mk(FUNC_FIND, $urandom_range(0, 63), $urandom_range(0, 1),
                       ($urandom_range(0, 9) == 0) ? full_coord() : $urandom_range(0, 16) - 8,
                       ($urandom_range(0, 9) == 0) ? full_coord() : $urandom_range(0, 16) - 8,
                       pick_dim(24, 5), pick_dim(24, 5), pick_coord(10), pick_coord(10),
                       full_coord(), full_coord());
            end else if (r < 98) begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
                c = raw[$bits(t_cmd)-1:0];
                c.func = FUNC_SPARE;
                push_cmd(c, 0);
                continue;
            end else begin
                raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
                c = raw[$bits(t_cmd)-1:0];
                c.func = (c.func[0]) ? FUNC_WRITE : FUNC_FIND;
            end
            push_cmd(c, n_gen % 150 == 149);
            n_gen++;
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start || pending_results.size() != 0 || busy)
            @(posedge i_clk);
        repeat (MAX_ENTRIES + 16) @(posedge i_clk);

        $display("Covered %0d writes, %0d moves (%0d blocked), %0d finds (%0d hits), %0d ignored",
                 cnt_write, cnt_move, cnt_blocked, cnt_find, cnt_hit, cnt_ignored);
        $display("Checked %0d results, %0d failures", n_results, fail_cnt);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### box_collision_move_resolver_top.f
hdl/bcmr_pkg.sv
hdl/bcmr_dp.sv
hdl/bcmr_ctrl.sv
hdl/box_collision_move_resolver_top.sv
verif/tb_box_collision_move_resolver_top.sv
